@@ design/dqtlsb_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the DQT low-bit message extractor.
package dqtlsb_pkg;

  localparam logic [7:0] MarkerPrefix = 8'hFF;
  localparam logic [7:0] MarkerDqt    = 8'hDB;

  // data bytes per quantisation table, the id byte comes on top
  localparam logic [6:0] TableDataBytes = 7'd64;

  localparam int TablesW = 10;

  // (len - 2) / 65 as a multiply by ceil(2^22 / 65), exact for 16-bit lengths
  localparam logic [15:0] LenRecip      = 16'd64528;
  localparam int          LenRecipShift = 22;

  typedef enum logic [5:0] {
    PhSearch  = 6'b000001,
    PhAfterFf = 6'b000010,
    PhLenHi   = 6'b000100,
    PhLenLo   = 6'b001000,
    PhExtract = 6'b010000,
    PhDone    = 6'b100000
  } phase_e;

  typedef enum logic [1:0] {
    ModeBits1 = 2'd0,
    ModeBits2 = 2'd1,
    ModeBits4 = 2'd2,
    ModeBits8 = 2'd3
  } bits_mode_e;

  // carrier item handed from the parser to the packer
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } carrier_t;

endpackage

@@ design/dqt_lsb_message_extract.sv @@
`timescale 1ns / 1ps
// Top level of the DQT low-bit message extractor.
//
// Input channel: one byte of the JPEG file per item on data_byte_i, taken at
// an edge with push high and full low. Output channel: one extracted
// character per item on message_char_o with last_char_o flagging the final
// character of the table region, valid while empty is low and taken with pop.
// bits_mode_i (1, 2, 4 or 8 bits per carrier byte) is written with
// bits_mode_we_i by the user only while the block is idle; the block itself
// does not enforce this. Throughput is one byte per cycle while full is low.
// A parser stage updates its phase and counters as a byte is taken, a
// QUEUE_DEPTH item queue feeds the packer, and the packer fills a one-item
// output register, where a character lands after its byte passes the queue.
// When the receiver stalls the output item holds, the queue fills and full
// rises after QUEUE_DEPTH more carrier bytes; table id and header bytes
// bypass the queue. Reset returns the parser to marker search, empties the
// queue and output, and sets bits_mode to one bit per byte. After the last
// table the block takes and drops every byte until the next reset.
module dqt_lsb_message_extract #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] message_char_o,
  output logic       last_char_o,
  input  logic       bits_mode_we_i,
  input  logic [1:0] bits_mode_i
);

  logic                 in_take;
  logic                 front_push;
  dqtlsb_pkg::carrier_t front_item;
  logic                 fifo_full;
  logic                 fifo_empty;
  logic                 fifo_pop;
  dqtlsb_pkg::carrier_t fifo_item;

  assign full    = fifo_full;
  assign in_take = push && !fifo_full;

  dqtlsb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_take),
    .data_byte_i (data_byte_i),
    .item_push_o (front_push),
    .item_o      (front_item)
  );

  dqtlsb_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .item_i  (front_item),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .item_o  (fifo_item),
    .empty_o (fifo_empty)
  );

  dqtlsb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bits_mode_we_i (bits_mode_we_i),
    .bits_mode_i    (bits_mode_i),
    .item_valid_i   (!fifo_empty),
    .item_i         (fifo_item),
    .item_pop_o     (fifo_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .message_char_o (message_char_o),
    .last_char_o    (last_char_o)
  );

endmodule

@@ design/dqtlsb_front.sv @@
`timescale 1ns / 1ps
// Parser: finds the DQT segment, reads its length and forwards carrier bytes.
module dqtlsb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [7:0]          data_byte_i,
  output logic                item_push_o,
  output dqtlsb_pkg::carrier_t item_o
);

  dqtlsb_pkg::phase_e                  phase_d, phase_q;
  logic [7:0]                          len_hi_d, len_hi_q;
  logic [dqtlsb_pkg::TablesW-1:0]      tables_left_d, tables_left_q;
  logic [6:0]                          byte_in_table_d, byte_in_table_q;
  logic [15:0]                         seg_len;
  logic [15:0]                         seg_body;
  logic [31:0]                         recip_prod;
  logic [dqtlsb_pkg::TablesW-1:0]      num_tables;

  assign seg_len    = {len_hi_q, data_byte_i};
  assign seg_body   = (seg_len >= 16'd2) ? (seg_len - 16'd2) : 16'd0;
  assign recip_prod = 32'(seg_body) * 32'(dqtlsb_pkg::LenRecip);
  assign num_tables = recip_prod[dqtlsb_pkg::LenRecipShift +: dqtlsb_pkg::TablesW];

  always_comb begin
    phase_d          = phase_q;
    len_hi_d         = len_hi_q;
    tables_left_d    = tables_left_q;
    byte_in_table_d  = byte_in_table_q;
    item_push_o      = 1'b0;
    item_o.data_byte = data_byte_i;
    item_o.last      = 1'b0;
    if (valid_i) begin
      unique case (phase_q)
        dqtlsb_pkg::PhSearch: begin
          if (data_byte_i == dqtlsb_pkg::MarkerPrefix) begin
            phase_d = dqtlsb_pkg::PhAfterFf;
          end
        end
        dqtlsb_pkg::PhAfterFf: begin
          phase_d = (data_byte_i == dqtlsb_pkg::MarkerDqt) ? dqtlsb_pkg::PhLenHi
                                                           : dqtlsb_pkg::PhSearch;
        end
        dqtlsb_pkg::PhLenHi: begin
          len_hi_d = data_byte_i;
          phase_d  = dqtlsb_pkg::PhLenLo;
        end
        dqtlsb_pkg::PhLenLo: begin
          tables_left_d   = num_tables;
          byte_in_table_d = dqtlsb_pkg::TableDataBytes;
          phase_d = (num_tables == '0) ? dqtlsb_pkg::PhDone : dqtlsb_pkg::PhExtract;
        end
        dqtlsb_pkg::PhExtract: begin
          if (byte_in_table_q >= dqtlsb_pkg::TableDataBytes) begin
            byte_in_table_d = 7'd0; // table id
          end else begin
            item_push_o     = 1'b1;
            byte_in_table_d = byte_in_table_q + 7'd1;
            if (byte_in_table_q == dqtlsb_pkg::TableDataBytes - 7'd1) begin
              tables_left_d = tables_left_q - 1'b1;
              if (tables_left_q == dqtlsb_pkg::TablesW'(1)) begin
                item_o.last = 1'b1;
                phase_d     = dqtlsb_pkg::PhDone;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= dqtlsb_pkg::PhSearch;
      len_hi_q        <= 8'd0;
      tables_left_q   <= '0;
      byte_in_table_q <= dqtlsb_pkg::TableDataBytes;
    end else begin
      phase_q         <= phase_d;
      len_hi_q        <= len_hi_d;
      tables_left_q   <= tables_left_d;
      byte_in_table_q <= byte_in_table_d;
    end
  end

endmodule

@@ design/dqtlsb_fifo.sv @@
`timescale 1ns / 1ps
// Short queue of carrier items between the parser and the packer.
module dqtlsb_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  dqtlsb_pkg::carrier_t item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output dqtlsb_pkg::carrier_t item_o,
  output logic                 empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  dqtlsb_pkg::carrier_t slot_q [DEPTH];
  logic [PtrW-1:0]      wr_ptr_d, wr_ptr_q;
  logic [PtrW-1:0]      rd_ptr_d, rd_ptr_q;
  logic [CntW-1:0]      count_d, count_q;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ design/dqtlsb_back.sv @@
`timescale 1ns / 1ps
// Packer: merges low bit groups into characters and holds the output item.
module dqtlsb_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 bits_mode_we_i,
  input  logic [1:0]           bits_mode_i,
  input  logic                 item_valid_i,
  input  dqtlsb_pkg::carrier_t item_i,
  output logic                 item_pop_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output logic [7:0]           message_char_o,
  output logic                 last_char_o
);

  dqtlsb_pkg::bits_mode_e mode_q;
  logic [7:0]             accum_d, accum_q;
  logic [2:0]             bit_pos_d, bit_pos_q;
  logic                   out_valid_d, out_valid_q;
  logic [7:0]             char_q;
  logic                   last_q;
  logic [7:0]             accum_next;
  logic [3:0]             groups;
  logic                   char_done;
  logic                   take;

  assign empty_o        = !out_valid_q;
  assign message_char_o = char_q;
  assign last_char_o    = last_q;

  assign take       = item_valid_i && (!out_valid_q || pop_i);
  assign item_pop_o = take;

  always_comb begin
    unique case (mode_q)
      dqtlsb_pkg::ModeBits1: begin
        accum_next = {accum_q[6:0], item_i.data_byte[0]};
        groups     = 4'd8;
      end
      dqtlsb_pkg::ModeBits2: begin
        accum_next = {accum_q[5:0], item_i.data_byte[1:0]};
        groups     = 4'd4;
      end
      dqtlsb_pkg::ModeBits4: begin
        accum_next = {accum_q[3:0], item_i.data_byte[3:0]};
        groups     = 4'd2;
      end
      default: begin
        accum_next = item_i.data_byte;
        groups     = 4'd1;
      end
    endcase
  end

  // a mode change mid-character may leave more groups than needed
  assign char_done = ({1'b0, bit_pos_q} + 4'd1) >= groups;

  always_comb begin
    accum_d     = accum_q;
    bit_pos_d   = bit_pos_q;
    out_valid_d = out_valid_q;
    if (pop_i) begin
      out_valid_d = 1'b0;
    end
    if (take) begin
      if (char_done) begin
        out_valid_d = 1'b1;
        accum_d     = 8'd0;
        bit_pos_d   = 3'd0;
      end else begin
        accum_d   = accum_next;
        bit_pos_d = bit_pos_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= dqtlsb_pkg::ModeBits1;
      accum_q     <= 8'd0;
      bit_pos_q   <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (bits_mode_we_i) begin
        mode_q <= dqtlsb_pkg::bits_mode_e'(bits_mode_i);
      end
      accum_q     <= accum_d;
      bit_pos_q   <= bit_pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && char_done) begin
      char_q <= accum_next;
      last_q <= item_i.last;
    end
  end

endmodule

@@ design/dqtlsb_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks of the DQT low-bit message extractor, bound to the top.
module dqtlsb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic       pop,
  input logic       empty,
  input logic [7:0] message_char_o,
  input logic       last_char_o
);

  logic [2:0] taken_q;
  logic       seen_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q     <= 3'd0;
      seen_last_q <= 1'b0;
    end else begin
      if (push && !full && (taken_q != 3'd7)) begin
        taken_q <= taken_q + 3'd1;
      end
      if (pop && !empty && last_char_o) begin
        seen_last_q <= 1'b1;
      end
    end
  end

  a_empty_in_reset: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result offered during reset");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(message_char_o) && $stable(last_char_o)))
    else $error("waiting result changed or vanished");

  // marker, length and table id precede the first carrier byte
  a_header_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (taken_q >= 3'd6))
    else $error("result before any carrier byte");

  a_nothing_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_last_q |-> empty)
    else $error("result after the final character");

endmodule

bind dqt_lsb_message_extract dqtlsb_checker u_checker (.*);
